// ===== hw/rtl/gbn_pkg.sv =====
// Shared types and constants for the go-back-n sender window.
`timescale 1ns / 1ps
package gbn_pkg;

  localparam int WINDOW      = 10;
  localparam int SEQ_SPACE   = 25601;
  localparam int MAX_PAYLOAD = 512;

  localparam int SEQ_W = 15;
  localparam int LEN_W = 10;
  localparam int TMR_W = 16;
  localparam int ACT_W = 2;
  localparam int KND_W = 3;
  localparam int IDX_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);

  // action codes on the input channel
  localparam logic [ACT_W-1:0] ACT_SEND = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ACK  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK = 2'd2;

  // result kinds
  localparam logic [KND_W-1:0] KIND_SENT    = 3'd0;
  localparam logic [KND_W-1:0] KIND_RESENT  = 3'd1;
  localparam logic [KND_W-1:0] KIND_REFUSED = 3'd2;
  localparam logic [KND_W-1:0] KIND_ACKED   = 3'd3;
  localparam logic [KND_W-1:0] KIND_IGNORED = 3'd4;

  // register indexes
  localparam logic REG_FIRST_SEQ = 1'b0;
  localparam logic REG_TIMEOUT   = 1'b1;

  localparam logic [SEQ_W:0]   SEQ_SPACE_V = (SEQ_W + 1)'(SEQ_SPACE);
  localparam logic [LEN_W-1:0] MAX_LEN_V   = LEN_W'(MAX_PAYLOAD);
  localparam logic [IDX_W:0]   WINDOW_V    = (IDX_W + 1)'(WINDOW);
  localparam logic [CNT_W-1:0] WINDOW_CNT  = CNT_W'(WINDOW);

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [LEN_W-1:0] len;
    logic [SEQ_W-1:0] ack;
  } cmd_t;

  typedef struct packed {
    logic [KND_W-1:0] kind;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] cnt;
    logic             last;
  } res_t;

  // sum of two ring indexes, wrapping at the window size
  function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= WINDOW_V) s = s - WINDOW_V;
    return s[IDX_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/gbn_front.sv =====
// Front end: classifies input items, saturates lengths, drops unknown actions.
`timescale 1ns / 1ps
module gbn_front (
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                action_i,
  input  logic [9:0]                segment_length_i,
  input  logic [14:0]               ack_number_i,
  output logic                      push_o,
  output gbn_pkg::cmd_t             cmd_o,
  input  logic                      q_ready_i
);
  import gbn_pkg::*;

  logic known;

  assign in_ready_o = q_ready_i;

  always_comb begin
    known     = 1'b1;
    cmd_o.op  = OP_SEND;
    cmd_o.len = (segment_length_i > MAX_LEN_V) ? MAX_LEN_V : segment_length_i;
    cmd_o.ack = ack_number_i;
    case (action_i)
      ACT_SEND: cmd_o.op = OP_SEND;
      ACT_ACK:  cmd_o.op = OP_ACK;
      ACT_TICK: cmd_o.op = OP_TICK;
      default:  known = 1'b0;
    endcase
  end

  // unknown actions are taken and vanish
  assign push_o = in_valid_i && q_ready_i && known;

endmodule

// ===== hw/rtl/gbn_queue.sv =====
// Two-entry command queue between front and back.
`timescale 1ns / 1ps
module gbn_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gbn_pkg::cmd_t cmd_i,
  output logic          ready_o,
  output logic          valid_o,
  output gbn_pkg::cmd_t cmd_o,
  input  logic          pop_i
);
  import gbn_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cmd_i;
  end

endmodule

// ===== hw/rtl/gbn_back.sv =====
// Back end: window ring, retransmit timer, ack scan and resend sequencer.
`timescale 1ns / 1ps
module gbn_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  gbn_pkg::cmd_t        cmd_i,
  output logic                 cmd_pop_o,
  input  logic                 seq_load_i,
  input  logic [14:0]          first_seq_i,
  input  logic [15:0]          timeout_i,
  output logic                 res_valid_o,
  output gbn_pkg::res_t        res_o,
  input  logic                 res_ready_i
);
  import gbn_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_RESEND = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [SEQ_W-1:0] seq_mem_q [WINDOW];
  logic [LEN_W-1:0] len_mem_q [WINDOW];
  logic [SEQ_W-1:0] end_mem_q [WINDOW];
  logic [IDX_W-1:0] oldest_q, oldest_d, slot_q, slot_d;
  logic [CNT_W-1:0] outst_q, outst_d, k_q, k_d;
  logic [SEQ_W-1:0] next_q, next_d, ack_q, ack_d;
  logic [TMR_W-1:0] timer_q, timer_d, reload, tdec;
  res_t             res_q, res_d;
  logic             res_valid_q, res_valid_d;
  logic             out_free, we;
  logic [IDX_W-1:0] wslot;
  logic [SEQ_W:0]   nsum, nwrap, fwrap;
  logic [CNT_W-1:0] k_inc;

  assign reload   = (timeout_i == '0) ? TMR_W'(1) : timeout_i;
  assign out_free = !res_valid_q || res_ready_i;
  assign wslot    = idx_add(oldest_q, outst_q[IDX_W-1:0]);
  assign nsum     = {1'b0, next_q} + (SEQ_W + 1)'(cmd_i.len);
  assign nwrap    = (nsum >= SEQ_SPACE_V) ? nsum - SEQ_SPACE_V : nsum;
  assign fwrap    = ({1'b0, first_seq_i} >= SEQ_SPACE_V) ?
                    {1'b0, first_seq_i} - SEQ_SPACE_V : {1'b0, first_seq_i};
  assign tdec     = timer_q - TMR_W'(1);
  assign k_inc    = k_q + CNT_W'(1);

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    oldest_d    = oldest_q;
    outst_d     = outst_q;
    slot_d      = slot_q;
    k_d         = k_q;
    next_d      = next_q;
    ack_d       = ack_q;
    timer_d     = timer_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_ready_i;
    cmd_pop_o   = 1'b0;
    we          = 1'b0;
    if (seq_load_i) next_d = fwrap[SEQ_W-1:0];
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            OP_SEND: begin
              res_valid_d = 1'b1;
              res_d.last  = 1'b1;
              if (outst_q >= WINDOW_CNT) begin
                res_d.kind = KIND_REFUSED;
                res_d.seq  = '0;
                res_d.len  = '0;
                res_d.cnt  = outst_q;
              end else begin
                we         = 1'b1;
                next_d     = nwrap[SEQ_W-1:0];
                outst_d    = outst_q + CNT_W'(1);
                timer_d    = reload;
                res_d.kind = KIND_SENT;
                res_d.seq  = next_q;
                res_d.len  = cmd_i.len;
                res_d.cnt  = outst_d;
              end
            end
            OP_ACK: begin
              if (outst_q == '0) begin
                res_valid_d = 1'b1;
                res_d.kind  = KIND_IGNORED;
                res_d.seq   = '0;
                res_d.len   = '0;
                res_d.cnt   = outst_q;
                res_d.last  = 1'b1;
              end else begin
                ack_d   = cmd_i.ack;
                k_d     = '0;
                slot_d  = oldest_q;
                state_d = ST_SCAN;
              end
            end
            OP_TICK: begin
              if (timer_q != '0) begin
                timer_d = tdec;
                if (tdec == '0 && outst_q != '0) begin
                  timer_d = reload;
                  k_d     = '0;
                  slot_d  = oldest_q;
                  state_d = ST_RESEND;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // one segment end checked per cycle, oldest first; last may stall
        if (end_mem_q[slot_q] == ack_q) begin
          if (out_free) begin
            oldest_d    = idx_add(slot_q, IDX_W'(1));
            outst_d     = outst_q - k_inc;
            timer_d     = (outst_d == '0) ? '0 : reload;
            res_valid_d = 1'b1;
            res_d.kind  = KIND_ACKED;
            res_d.seq   = '0;
            res_d.len   = '0;
            res_d.cnt   = outst_d;
            res_d.last  = 1'b1;
            state_d     = ST_IDLE;
          end
        end else if (k_inc == outst_q) begin
          if (out_free) begin
            res_valid_d = 1'b1;
            res_d.kind  = KIND_IGNORED;
            res_d.seq   = '0;
            res_d.len   = '0;
            res_d.cnt   = outst_q;
            res_d.last  = 1'b1;
            state_d     = ST_IDLE;
          end
        end else begin
          k_d    = k_inc;
          slot_d = idx_add(slot_q, IDX_W'(1));
        end
      end
      ST_RESEND: begin
        if (out_free) begin
          res_valid_d = 1'b1;
          res_d.kind  = KIND_RESENT;
          res_d.seq   = seq_mem_q[slot_q];
          res_d.len   = len_mem_q[slot_q];
          res_d.cnt   = outst_q;
          res_d.last  = (k_inc == outst_q);
          k_d         = k_inc;
          slot_d      = idx_add(slot_q, IDX_W'(1));
          if (k_inc == outst_q) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      oldest_q    <= '0;
      outst_q     <= '0;
      slot_q      <= '0;
      k_q         <= '0;
      next_q      <= '0;
      timer_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      oldest_q    <= oldest_d;
      outst_q     <= outst_d;
      slot_q      <= slot_d;
      k_q         <= k_d;
      next_q      <= next_d;
      timer_q     <= timer_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ack_q <= ack_d;
    res_q <= res_d;
    if (we) begin
      seq_mem_q[wslot] <= next_q;
      len_mem_q[wslot] <= cmd_i.len;
      end_mem_q[wslot] <= nwrap[SEQ_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/go_back_n_sender_window.sv =====
// Top level of the go-back-n sender window: config registers and wiring.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------
//  in      | input     | in_valid_i / in_ready_o | action, segment_length, ack_number
//  out     | output    | out_valid_o/out_ready_i | kind, sequence_number, length_out,
//          |           |                         | unacked_count, last
//  cfg     | input     | psel/penable/pwrite     | paddr, pwdata, prdata
//
// A send or a refused send gives its registered result in the cycle after the back end pops it.
// An ack walks the stored segment ends one per cycle, oldest first, and holds on its
// final compare until the output is free; with nothing outstanding it gets an ignored result.
// A timeout resend run gives one item per cycle while the output is free, one per outstanding segment.
// Reset (rst_ni, async low) empties the window and stops the timer; no clear pass.
// The two-entry queue keeps taking items until full while the back end waits on out_ready_i.
`timescale 1ns / 1ps
module go_back_n_sender_window (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [9:0]  segment_length_i,
  input  logic [14:0] ack_number_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [14:0] sequence_number_o,
  output logic [9:0]  length_out_o,
  output logic [3:0]  unacked_count_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gbn_pkg::*;

  logic [SEQ_W-1:0] first_seq_q;
  logic [TMR_W-1:0] timeout_q;
  logic             cfg_we, seq_load;
  logic             push, q_ready, q_valid, pop;
  cmd_t             cmd_in, cmd_q;
  res_t             res;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite;
  // writing the first sequence also reloads the next sequence number
  assign seq_load = cfg_we && (paddr[2] == REG_FIRST_SEQ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_seq_q <= '0;
      timeout_q   <= TMR_W'(500);
    end else if (cfg_we) begin
      if (paddr[2] == REG_FIRST_SEQ) first_seq_q <= pwdata[SEQ_W-1:0];
      else                           timeout_q   <= pwdata[TMR_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_TIMEOUT) prdata = {16'd0, timeout_q};
    else                         prdata = {17'd0, first_seq_q};
  end

  gbn_front u_front (
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .segment_length_i (segment_length_i),
    .ack_number_i     (ack_number_i),
    .push_o           (push),
    .cmd_o            (cmd_in),
    .q_ready_i        (q_ready)
  );

  gbn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .cmd_o   (cmd_q),
    .pop_i   (pop)
  );

  gbn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (cmd_q),
    .cmd_pop_o   (pop),
    .seq_load_i  (seq_load),
    .first_seq_i (pwdata[SEQ_W-1:0]),
    .timeout_i   (timeout_q),
    .res_valid_o (out_valid_o),
    .res_o       (res),
    .res_ready_i (out_ready_i)
  );

  assign kind_o            = res.kind;
  assign sequence_number_o = res.seq;
  assign length_out_o      = res.len;
  assign unacked_count_o   = res.cnt;
  assign last_o            = res.last;

endmodule
